/* hw/rtl/smfr_pkg.sv */
// Shared types, codes and constants of the start/end marker frame receiver.
`timescale 1ns / 1ps
package smfr_pkg;

   localparam int PAYLOAD_LEN_DEFAULT = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] START_BYTE = 8'hAF;
   localparam logic [7:0] END_BYTE = 8'hEF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] TICK_MAX = 16'hFFFF;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_ERROR = 2'd1;
   localparam logic [1:0] OP_EMIT = 2'd2;

   typedef struct packed {
      logic [1:0] code;
      logic [7:0] data;
   } op_type;

endpackage

/* hw/rtl/smfr_front.sv */
// Front end: classifies requests, tracks the frame timer and issues operations.
`timescale 1ns / 1ps
module smfr_front
   import smfr_pkg::*;
#(
   parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output logic        push,
   output op_type      push_op,
   input  logic        queue_full
);

   localparam int CNT_W = $clog2(PAYLOAD_LEN + 1);

   logic [15:0]      timeout_ff, timeout_in;
   logic             collecting_ff, collecting_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      tick_ff, tick_in;
   logic             expired_ff, expired_in;
   logic [15:0]      tick_next;
   logic             accept;

   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;
   assign tick_next = (tick_ff != TICK_MAX) ? tick_ff + 16'd1 : tick_ff;

   always_comb begin
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      collecting_in = collecting_ff;
      count_in = count_ff;
      tick_in = tick_ff;
      expired_in = expired_ff;
      push = 1'b0;
      push_op.code = OP_STORE;
      push_op.data = req_tdata;
      if (accept) begin
         if (req_tuser == CMD_TICK) begin
            if (collecting_ff && !expired_ff) begin
               tick_in = tick_next;
               if (tick_next >= timeout_ff) begin
                  expired_in = 1'b1;
               end
            end
         end else if (!collecting_ff) begin
            if (req_tdata == START_BYTE) begin
               collecting_in = 1'b1;
               count_in = '0;
               tick_in = '0;
               expired_in = 1'b0;
            end
         end else if (expired_ff) begin
            push = 1'b1;
            push_op.code = OP_ERROR;
            expired_in = 1'b0;
            collecting_in = 1'b0;
            count_in = '0;
         end else if (count_ff < CNT_W'(PAYLOAD_LEN)) begin
            push = 1'b1;
            push_op.code = OP_STORE;
            count_in = count_ff + CNT_W'(1);
         end else begin
            push = 1'b1;
            push_op.code = (req_tdata == END_BYTE) ? OP_EMIT : OP_ERROR;
            collecting_in = 1'b0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         collecting_ff <= 1'b0;
         count_ff <= '0;
         tick_ff <= '0;
         expired_ff <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         collecting_ff <= collecting_in;
         count_ff <= count_in;
         tick_ff <= tick_in;
         expired_ff <= expired_in;
      end
   end

endmodule

/* hw/rtl/smfr_queue.sv */
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps
module smfr_queue
   import smfr_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output op_type head_op,
   output logic   empty
);

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/smfr_back.sv */
// Back end: payload memory, frame replay and the result output register.
`timescale 1ns / 1ps
module smfr_back
   import smfr_pkg::*;
#(
   parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  op_type     head_op,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [7:0]       store_mem [PAYLOAD_LEN];
   logic [7:0]       rd_data_ff;
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff, data_in;
   logic             kind_ff, kind_in;
   logic             last_ff, last_in;
   logic             mem_we, mem_re, out_free, load;

   assign out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = kind_ff;
   assign rsp_tlast = last_ff;

   always_comb begin
      state_in = state_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      pop = 1'b0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      load = 1'b0;
      data_in = data_ff;
      kind_in = kind_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               unique case (head_op.code)
                  OP_STORE: begin
                     mem_we = 1'b1;
                     wr_idx_in = wr_idx_ff + IDX_W'(1);
                     pop = 1'b1;
                  end
                  OP_ERROR: begin
                     if (out_free) begin
                        load = 1'b1;
                        kind_in = KIND_ERROR;
                        data_in = '0;
                        last_in = 1'b1;
                        wr_idx_in = '0;
                        pop = 1'b1;
                     end
                  end
                  OP_EMIT: begin
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                     pop = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_re = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               load = 1'b1;
               kind_in = KIND_PAYLOAD;
               data_in = rd_data_ff;
               last_in = (rd_idx_ff == IDX_W'(PAYLOAD_LEN - 1));
               if (rd_idx_ff == IDX_W'(PAYLOAD_LEN - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_idx_ff] <= head_op.data;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/start_end_marker_frame_receiver.sv */
// Frame receiver that collects payload bytes between start and end markers.
// Each request is a received byte or a timer tick and is accepted while the
// four-entry operation queue has room. A good frame is replayed from the payload
// memory result by result: each byte is first read from the memory and then loaded
// into the output register, which can hold the replay under back-pressure. An error
// result goes straight into the output register. Ticks are absorbed by the front end
// and never enter the queue, but they wait like bytes while the queue is full. Up to
// four bytes of the next frame can queue while the back end replays a frame.
`timescale 1ns / 1ps
module start_end_marker_frame_receiver
   import smfr_pkg::*;
#(
   parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic   push, queue_full, pop, queue_empty;
   op_type push_op, head_op;

   smfr_front #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   smfr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .push_op(push_op),
      .full   (queue_full),
      .pop    (pop),
      .head_op(head_op),
      .empty  (queue_empty)
   );

   smfr_back #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
